/* hw/rtl/qam16_burst_modulator_core_assert.svh */
// assertion macros for the qam16 burst modulator
`ifndef QAM16_BURST_MODULATOR_CORE_ASSERT_SVH
`define QAM16_BURST_MODULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define QAM16_CHECK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("qam16 check failed");
`define QAM16_CHECK_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("qam16 forbidden condition seen");
`else
`define QAM16_CHECK(lbl, clk_s, rstn_s, prop)
`define QAM16_CHECK_NEVER(lbl, clk_s, rstn_s, cond)
`endif

`endif

/* hw/rtl/qam16_pkg.sv */
// shared types, constants and carrier table for the qam16 burst modulator
`default_nettype none

package qam16_pkg;

  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int LVL_W     = $clog2(QDEPTH + 1);
  localparam int PKT_BITS  = 64;
  localparam int SYM_COUNT = PKT_BITS / 4;
  localparam int SYM_W     = $clog2(SYM_COUNT + 1);
  localparam int NIB_W     = $clog2(SYM_COUNT);
  localparam int TBL_SIZE  = 128;
  localparam int PHASE_W   = $clog2(TBL_SIZE);
  localparam int QTR       = TBL_SIZE / 4;
  localparam int QIDX_W    = $clog2(QTR + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 2'd2;

  localparam logic [7:0]  DC_OFFSET_RST = 8'd88;
  localparam logic [15:0] GAIN_RST      = 16'd5800;
  localparam logic [3:0]  REPEAT_RST    = 4'd2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // level codes of a 2-bit half nibble
  localparam logic [1:0] LVL_M3 = 2'd0;
  localparam logic [1:0] LVL_M1 = 2'd1;
  localparam logic [1:0] LVL_P3 = 2'd2;
  localparam logic [1:0] LVL_P1 = 2'd3;

  // trunc(127 * sin(m * pi / 64)), m = 0 .. 32
  localparam logic [6:0] QTAB [QTR+1] = '{
    7'd0,   7'd6,   7'd12,  7'd18,  7'd24,  7'd30,  7'd36,  7'd42,
    7'd48,  7'd54,  7'd59,  7'd65,  7'd70,  7'd75,  7'd80,  7'd85,
    7'd89,  7'd94,  7'd98,  7'd102, 7'd105, 7'd108, 7'd112, 7'd114,
    7'd117, 7'd119, 7'd121, 7'd123, 7'd124, 7'd125, 7'd126, 7'd126,
    7'd127
  };

  typedef struct packed {
    logic              en;
    logic [QPTR_W-1:0] addr;
    logic [PKT_BITS-1:0] data;
  } pkt_wr_t;

  typedef struct packed {
    logic              en;
    logic [QPTR_W-1:0] addr;
  } pkt_rd_t;

  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         w_cos;
    logic [1:0]         w_sin;
  } samp_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] sample;
  } samp_rsp_t;

  // signed sine of one table phase, built from the quarter wave
  function automatic logic signed [7:0] carrier(input logic [PHASE_W-1:0] idx);
    logic [1:0]        quad;
    logic [4:0]        m;
    logic [QIDX_W-1:0] qi;
    logic [7:0]        mag;
    quad = idx[PHASE_W-1 -: 2];
    m    = idx[4:0];
    qi   = quad[0] ? QIDX_W'(QTR - int'(m)) : QIDX_W'(m);
    mag  = {1'b0, QTAB[qi]};
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  // carrier value times the level of one code
  function automatic logic signed [9:0] weighted(input logic signed [7:0] v,
                                                 input logic [1:0] code);
    logic signed [9:0] v10;
    logic signed [9:0] v3;
    v10 = {{2{v[7]}}, v};
    v3  = v10 + (v10 <<< 1);
    unique case (code)
      LVL_M3: return -v3;
      LVL_M1: return -v10;
      LVL_P3: return v3;
      LVL_P1: return v10;
    endcase
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/qam16_burst_modulator_core.sv */
// top level of the 16-qam burst modulator: queue control, symbol sequencing, output register
// a push result passes through the result and output registers; a tick result also passes
//   the packet store read and the three-stage sample datapath before them; a new item is taken
//   only once the previous result has moved into the output register
// reset: synchronous active-low; clears control, counters and config to defaults
// packet store contents stay undefined until written; no clearing pass is run
`default_nettype none

module qam16_burst_modulator_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // item channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic [qam16_pkg::PKT_BITS-1:0]      in_packet_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_push_accepted,
  output logic                                     out_sample_valid,
  output logic [7:0]                               out_dac_sample,
  output logic                                     out_sending,
  output logic                                     out_packet_done,
  output logic [qam16_pkg::LVL_W-1:0]              out_queue_level,
  // register write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [qam16_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [qam16_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  `include "qam16_burst_modulator_core_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_SYM,
    S_CALC,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [7:0]  dc_offset_r, dc_offset_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [3:0]  repeat_r, repeat_nxt;

  // queue pointers and fill level
  logic [qam16_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [qam16_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic [qam16_pkg::LVL_W-1:0]  count_r, count_nxt;

  // transmit sequencing state
  logic [qam16_pkg::PKT_BITS-1:0] cur_pkt_r, cur_pkt_nxt;
  logic [qam16_pkg::SYM_W-1:0]    sym_r, sym_nxt;
  logic [3:0]                     per_r, per_nxt;
  logic [qam16_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic                           busy_r, busy_nxt;

  // context of the tick in flight
  logic                           ctx_load_r, ctx_load_nxt;
  logic                           ctx_use_r, ctx_use_nxt;
  logic [qam16_pkg::NIB_W-1:0]    ctx_sym_r, ctx_sym_nxt;
  logic [qam16_pkg::PHASE_W-1:0]  ctx_phase_r, ctx_phase_nxt;

  // pending result
  logic                          res_acc_r, res_acc_nxt;
  logic                          res_valid_r, res_valid_nxt;
  logic [7:0]                    res_sample_r, res_sample_nxt;
  logic                          res_sending_r, res_sending_nxt;
  logic                          res_done_r, res_done_nxt;
  logic [qam16_pkg::LVL_W-1:0]   res_level_r, res_level_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_acc_r, out_acc_nxt;
  logic                          out_svalid_r, out_svalid_nxt;
  logic [7:0]                    out_sample_r, out_sample_nxt;
  logic                          out_sending_r, out_sending_nxt;
  logic                          out_done_r, out_done_nxt;
  logic [qam16_pkg::LVL_W-1:0]   out_level_r, out_level_nxt;

  qam16_pkg::pkt_wr_t    mem_wr;
  qam16_pkg::pkt_rd_t    mem_rd;
  logic [qam16_pkg::PKT_BITS-1:0] mem_rdata;
  qam16_pkg::samp_req_t  dp_req;
  qam16_pkg::samp_rsp_t  dp_rsp;

  // tick helpers
  logic                           in_acc;
  logic                           load;
  logic                           busy_e;
  logic [qam16_pkg::SYM_W-1:0]    sym_e;
  logic [3:0]                     per_e;
  logic [3:0]                     reps;
  logic [4:0]                     per_inc;
  logic [qam16_pkg::SYM_W-1:0]    sym_inc;
  logic                           wrap;
  logic [qam16_pkg::SYM_COUNT-1:0][3:0] pkt_nib;
  logic [3:0]                     nib;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // tick bookkeeping, all from the state before the tick
  always_comb begin
    reps    = (repeat_r == 4'd0) ? 4'd1 : repeat_r;
    load    = !busy_r && (phase_r == '0) && (count_r != '0);
    busy_e  = busy_r || load;
    sym_e   = load ? '0 : sym_r;
    per_e   = load ? 4'd0 : per_r;
    per_inc = {1'b0, per_e} + 5'd1;
    sym_inc = sym_e + qam16_pkg::SYM_W'(1);
    wrap    = (phase_r == qam16_pkg::PHASE_W'(qam16_pkg::TBL_SIZE - 1));
  end

  // nibble of the current symbol, msb first
  always_comb begin
    pkt_nib = ctx_load_r ? mem_rdata : cur_pkt_r;
    nib     = pkt_nib[qam16_pkg::NIB_W'(qam16_pkg::SYM_COUNT - 1) - ctx_sym_r];
  end

  always_comb begin
    state_nxt       = state_r;
    dc_offset_nxt   = dc_offset_r;
    gain_nxt        = gain_r;
    repeat_nxt      = repeat_r;
    wp_nxt          = wp_r;
    rp_nxt          = rp_r;
    count_nxt       = count_r;
    cur_pkt_nxt     = cur_pkt_r;
    sym_nxt         = sym_r;
    per_nxt         = per_r;
    phase_nxt       = phase_r;
    busy_nxt        = busy_r;
    ctx_load_nxt    = ctx_load_r;
    ctx_use_nxt     = ctx_use_r;
    ctx_sym_nxt     = ctx_sym_r;
    ctx_phase_nxt   = ctx_phase_r;
    res_acc_nxt     = res_acc_r;
    res_valid_nxt   = res_valid_r;
    res_sample_nxt  = res_sample_r;
    res_sending_nxt = res_sending_r;
    res_done_nxt    = res_done_r;
    res_level_nxt   = res_level_r;
    out_valid_nxt   = out_valid_r;
    out_acc_nxt     = out_acc_r;
    out_svalid_nxt  = out_svalid_r;
    out_sample_nxt  = out_sample_r;
    out_sending_nxt = out_sending_r;
    out_done_nxt    = out_done_r;
    out_level_nxt   = out_level_r;

    mem_wr.en   = 1'b0;
    mem_wr.addr = wp_r;
    mem_wr.data = in_packet_data;
    mem_rd.en   = 1'b0;
    mem_rd.addr = rp_r;

    dp_req.start = 1'b0;
    dp_req.phase = ctx_phase_r;
    dp_req.w_cos = ctx_use_r ? nib[3:2] : qam16_pkg::LVL_P1;
    dp_req.w_sin = ctx_use_r ? nib[1:0] : qam16_pkg::LVL_P1;

    // register writes are to arrive only while the block is idle; the block itself does not enforce this
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qam16_pkg::CFG_DC_OFFSET: dc_offset_nxt = cfg_wdata[7:0];
        qam16_pkg::CFG_GAIN:      gain_nxt      = cfg_wdata[15:0];
        qam16_pkg::CFG_REPEAT:    repeat_nxt    = cfg_wdata[3:0];
        default: ;
      endcase
    end

    // result taken downstream frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == qam16_pkg::OP_PUSH) begin
            res_acc_nxt = 1'b0;
            if (count_r < qam16_pkg::LVL_W'(qam16_pkg::QDEPTH)) begin
              mem_wr.en   = 1'b1;
              wp_nxt      = wp_r + qam16_pkg::QPTR_W'(1);
              count_nxt   = count_r + qam16_pkg::LVL_W'(1);
              res_acc_nxt = 1'b1;
            end
            res_valid_nxt   = 1'b0;
            res_sample_nxt  = 8'd0;
            res_sending_nxt = busy_r;
            res_done_nxt    = 1'b0;
            res_level_nxt   = count_nxt;
            state_nxt       = S_RESULT;
          end else begin
            // packet starts at a carrier period boundary, fetched from the store
            if (load) begin
              mem_rd.en = 1'b1;
              rp_nxt    = rp_r + qam16_pkg::QPTR_W'(1);
              count_nxt = count_r - qam16_pkg::LVL_W'(1);
            end
            ctx_load_nxt  = load;
            ctx_use_nxt   = busy_e && (sym_e < qam16_pkg::SYM_W'(qam16_pkg::SYM_COUNT));
            ctx_sym_nxt   = sym_e[qam16_pkg::NIB_W-1:0];
            ctx_phase_nxt = phase_r;

            res_acc_nxt     = 1'b0;
            res_valid_nxt   = 1'b1;
            res_sending_nxt = busy_e;
            res_done_nxt    = busy_e
                              && (sym_e >= qam16_pkg::SYM_W'(qam16_pkg::SYM_COUNT))
                              && (per_inc >= {1'b0, reps}) && wrap;
            res_level_nxt   = count_nxt;

            // advance phase, period and symbol counters
            phase_nxt = phase_r + qam16_pkg::PHASE_W'(1);
            busy_nxt  = busy_e;
            sym_nxt   = sym_e;
            per_nxt   = per_e;
            if (wrap && busy_e) begin
              if (per_inc >= {1'b0, reps}) begin
                per_nxt = 4'd0;
                if (sym_inc > qam16_pkg::SYM_W'(qam16_pkg::SYM_COUNT)) begin
                  sym_nxt  = '0;
                  busy_nxt = 1'b0;
                end else begin
                  sym_nxt = sym_inc;
                end
              end else begin
                per_nxt = per_inc[3:0];
              end
            end
            state_nxt = S_SYM;
          end
        end
      end
      S_SYM: begin
        // store data is ready now; hand the symbol weights to the datapath
        if (ctx_load_r) begin
          cur_pkt_nxt = mem_rdata;
        end
        dp_req.start = 1'b1;
        state_nxt    = S_CALC;
      end
      S_CALC: begin
        if (dp_rsp.done) begin
          res_sample_nxt = dp_rsp.sample;
          state_nxt      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_acc_nxt     = res_acc_r;
          out_svalid_nxt  = res_valid_r;
          out_sample_nxt  = res_sample_r;
          out_sending_nxt = res_sending_r;
          out_done_nxt    = res_done_r;
          out_level_nxt   = res_level_r;
          state_nxt       = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dc_offset_r <= qam16_pkg::DC_OFFSET_RST;
      gain_r      <= qam16_pkg::GAIN_RST;
      repeat_r    <= qam16_pkg::REPEAT_RST;
      wp_r        <= '0;
      rp_r        <= '0;
      count_r     <= '0;
      sym_r       <= '0;
      per_r       <= 4'd0;
      phase_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dc_offset_r <= dc_offset_nxt;
      gain_r      <= gain_nxt;
      repeat_r    <= repeat_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      count_r     <= count_nxt;
      sym_r       <= sym_nxt;
      per_r       <= per_nxt;
      phase_r     <= phase_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    cur_pkt_r     <= cur_pkt_nxt;
    ctx_load_r    <= ctx_load_nxt;
    ctx_use_r     <= ctx_use_nxt;
    ctx_sym_r     <= ctx_sym_nxt;
    ctx_phase_r   <= ctx_phase_nxt;
    res_acc_r     <= res_acc_nxt;
    res_valid_r   <= res_valid_nxt;
    res_sample_r  <= res_sample_nxt;
    res_sending_r <= res_sending_nxt;
    res_done_r    <= res_done_nxt;
    res_level_r   <= res_level_nxt;
    out_acc_r     <= out_acc_nxt;
    out_svalid_r  <= out_svalid_nxt;
    out_sample_r  <= out_sample_nxt;
    out_sending_r <= out_sending_nxt;
    out_done_r    <= out_done_nxt;
    out_level_r   <= out_level_nxt;
  end

  qam16_pkt_mem u_pkt_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rdata)
  );

  qam16_sample_dp u_sample_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dc_offset (dc_offset_r),
    .gain      (gain_r),
    .req       (dp_req),
    .rsp       (dp_rsp)
  );

  assign out_valid         = out_valid_r;
  assign out_push_accepted = out_acc_r;
  assign out_sample_valid  = out_svalid_r;
  assign out_dac_sample    = out_sample_r;
  assign out_sending       = out_sending_r;
  assign out_packet_done   = out_done_r;
  assign out_queue_level   = out_level_r;

  // queue level never passes the store depth
  `QAM16_CHECK(a_level_bound, clk, rst_n, count_r <= qam16_pkg::LVL_W'(qam16_pkg::QDEPTH))
  // a burst ends only on a carrier period boundary
  `QAM16_CHECK(a_end_on_boundary, clk, rst_n, $fell(busy_r) |-> (phase_r == '0))
  // datapath results only show up while a tick is waiting for them
  `QAM16_CHECK(a_dp_in_calc, clk, rst_n, dp_rsp.done |-> (state_r == S_CALC))
  // symbol fetch follows an accepted tick
  `QAM16_CHECK(a_sym_after_tick, clk, rst_n,
    (state_r == S_SYM) |-> $past(in_acc && (in_opcode == qam16_pkg::OP_TICK)))

endmodule

`default_nettype wire

/* hw/rtl/qam16_pkt_mem.sv */
// packet store: synchronous memory, one write and one registered read port
`default_nettype none

module qam16_pkt_mem (
  input  wire logic                         clk,
  input  wire qam16_pkg::pkt_wr_t           wr,
  input  wire qam16_pkg::pkt_rd_t           rd,
  output logic [qam16_pkg::PKT_BITS-1:0]    rd_data
);

  logic [qam16_pkg::PKT_BITS-1:0] mem [qam16_pkg::QDEPTH];
  logic [qam16_pkg::PKT_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/qam16_sample_dp.sv */
// three-stage sample datapath: iq sum, gain multiply, round and saturate
`default_nettype none

module qam16_sample_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [7:0]            dc_offset,
  input  wire logic [15:0]           gain,
  input  wire qam16_pkg::samp_req_t  req,
  output qam16_pkg::samp_rsp_t       rsp
);

  logic              v1_r, v2_r, v3_r;
  logic signed [10:0] acc_r, acc_nxt;
  logic signed [27:0] prod_r, prod_nxt;
  logic [7:0]         sample_r, sample_nxt;

  logic signed [7:0]  s_val, c_val;
  logic signed [9:0]  ws, wc;
  logic               neg;
  logic [27:0]        mag;
  logic [11:0]        q;
  logic signed [12:0] val, sum;

  always_comb begin
    s_val   = qam16_pkg::carrier(req.phase);
    c_val   = qam16_pkg::carrier(req.phase + qam16_pkg::PHASE_W'(qam16_pkg::QTR));
    ws      = qam16_pkg::weighted(s_val, req.w_sin);
    wc      = qam16_pkg::weighted(c_val, req.w_cos);
    acc_nxt = {ws[9], ws} + {wc[9], wc};
  end

  assign prod_nxt = acc_r * $signed({1'b0, gain});

  // scale back by 2^16 with truncation toward zero
  always_comb begin
    neg = prod_r[27];
    mag = neg ? 28'(-prod_r) : 28'(prod_r);
    q   = mag[27:16];
    val = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    sum = $signed({5'd0, dc_offset}) + val;
    if (sum < 0) begin
      sample_nxt = 8'd0;
    end else if (sum > 13'sd255) begin
      sample_nxt = 8'd255;
    end else begin
      sample_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    prod_r   <= prod_nxt;
    sample_r <= sample_nxt;
  end

  assign rsp.done   = v3_r;
  assign rsp.sample = sample_r;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the qam16 burst modulator core
`timescale 1ns / 1ps

module tb_top;

  // own copies of the block's dimensions, kept apart from the rtl package
  localparam int CAR_LEN     = 128;
  localparam int NIBBLES     = 16;
  localparam int STORE_DEPTH = 8;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 12;
  localparam int MAX_REPORTS = 25;

  // register index with no register behind it, writes there change nothing
  localparam logic [qam16_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // pacing modes for both sides
  localparam int PACE_FULL   = 0;
  localparam int PACE_RANDOM = 1;
  localparam int PACE_BURSTY = 2;

  typedef struct packed {
    logic                        push_ok;
    logic                        is_sample;
    logic [7:0]                  dac;
    logic                        busy;
    logic                        last;
    logic [qam16_pkg::LVL_W-1:0] level;
  } mod_result_t;

  typedef struct {
    logic        op;
    logic [63:0] data;
    int          gap;
  } stim_item_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                             in_valid;
  logic                             in_stall;
  logic                             in_opcode;
  logic [qam16_pkg::PKT_BITS-1:0]   in_packet_data;
  logic                             out_valid;
  logic                             out_stall;
  logic                             out_push_accepted;
  logic                             out_sample_valid;
  logic [7:0]                       out_dac_sample;
  logic                             out_sending;
  logic                             out_packet_done;
  logic [qam16_pkg::LVL_W-1:0]      out_queue_level;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [qam16_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qam16_pkg::CFG_DATA_W-1:0] cfg_wdata;

  always #5 clk = ~clk;

  qam16_burst_modulator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_packet_data    (in_packet_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_push_accepted (out_push_accepted),
    .out_sample_valid  (out_sample_valid),
    .out_dac_sample    (out_dac_sample),
    .out_sending       (out_sending),
    .out_packet_done   (out_packet_done),
    .out_queue_level   (out_queue_level),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // modulator prediction: carrier tables, packet queue, symbol sequencer
  // ---------------------------------------------------------------------------
  int          sine_lut   [CAR_LEN];
  int          cosine_lut [CAR_LEN];
  logic [63:0] pkt_store  [STORE_DEPTH];
  logic [2:0]  store_wr;
  logic [2:0]  store_rd;
  int          pkt_count;
  logic [63:0] tx_word;
  int          sym_pos;
  int          rep_done;
  int          car_phase;
  bit          tx_active;
  int          dc_code;
  int          gain_q16;
  int          reps_cfg;

  // trunc(127 * sin(2*pi*a/512)) from a q30 taylor series, quarter wave folded
  function automatic int trunc127_sine(input longint unsigned a);
    longint unsigned quad, r, t, t2, term, dv, mag, n;
    longint          sum;
    bit              use_cos;
    int              v;
    quad    = (a / CAR_LEN) & 3;
    r       = a % CAR_LEN;
    t       = (64'd1686629713 * r) / CAR_LEN;
    use_cos = quad[0];
    t2      = (t * t) >> 30;
    term    = use_cos ? (64'd1 << 30) : t;
    sum     = $signed(term);
    for (n = 1; n <= 7; n++) begin
      dv   = use_cos ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
      term = ((term * t2) >> 30) / dv;
      if (n[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    mag = (sum < 0) ? 64'd0 : $unsigned(sum);
    v   = int'((mag * 127) >> 30);
    if (v > 127) v = 127;
    return (quad >= 2) ? -v : v;
  endfunction

  function automatic int level_of(input logic [1:0] code);
    case (code)
      qam16_pkg::LVL_M3: return -3;
      qam16_pkg::LVL_M1: return -1;
      qam16_pkg::LVL_P3: return 3;
      default:           return 1;
    endcase
  endfunction

  // one transaction through the modulator, updates the predicted state
  function automatic mod_result_t modulate_step(input logic op, input logic [63:0] data);
    mod_result_t r;
    int          w_sin, w_cos, reps, ph;
    logic [3:0]  nib;
    longint      acc, scaled, val, s;
    r = '0;
    if (op == qam16_pkg::OP_PUSH) begin
      if (pkt_count < STORE_DEPTH) begin
        pkt_store[store_wr] = data;
        store_wr  = store_wr + 3'd1;
        pkt_count = pkt_count + 1;
        r.push_ok = 1'b1;
      end
      r.busy = tx_active;
    end else begin
      w_sin = 1;
      w_cos = 1;
      reps  = (reps_cfg == 0) ? 1 : reps_cfg;
      ph    = car_phase;
      // a waiting packet only starts on a carrier period boundary
      if (!tx_active && ph == 0 && pkt_count > 0) begin
        tx_word   = pkt_store[store_rd];
        store_rd  = store_rd + 3'd1;
        pkt_count = pkt_count - 1;
        tx_active = 1'b1;
        sym_pos   = 0;
        rep_done  = 0;
      end
      // data nibbles msb first, the stop symbol and idle keep weights (1,1)
      if (tx_active && sym_pos < NIBBLES) begin
        nib   = 4'(tx_word >> (60 - 4 * sym_pos));
        w_cos = level_of(nib[3:2]);
        w_sin = level_of(nib[1:0]);
      end
      acc    = longint'(sine_lut[ph]) * w_sin + longint'(cosine_lut[ph]) * w_cos;
      scaled = acc * gain_q16;
      if (scaled < 0) val = -((-scaled) >>> 16);
      else            val = scaled >>> 16;
      s = dc_code + val;
      if (s < 0)   s = 0;
      if (s > 255) s = 255;
      r.is_sample = 1'b1;
      r.dac       = 8'(s);
      r.busy      = tx_active;
      r.last      = tx_active && sym_pos >= NIBBLES && rep_done + 1 >= reps
                    && ph == CAR_LEN - 1;
      ph = ph + 1;
      if (ph >= CAR_LEN) begin
        ph = 0;
        if (tx_active) begin
          rep_done = rep_done + 1;
          if (rep_done >= reps) begin
            rep_done = 0;
            sym_pos  = sym_pos + 1;
            if (sym_pos > NIBBLES) begin
              sym_pos   = 0;
              tx_active = 1'b0;
            end
          end
        end
      end
      car_phase = ph;
    end
    r.level = qam16_pkg::LVL_W'(pkt_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  stim_item_t  pending_items[$];
  mod_result_t expected_results[$];

  int gap_mode;
  int stall_mode;
  int hold_requests;
  int holds_served;
  int fail_count;
  int items_taken;
  int samples_checked;
  int pushes_stored;
  int pushes_refused;
  int bursts_finished;
  int reg_writes;

  bit in_taken;
  bit out_taken;

  function automatic int draw_pause(input int mode);
    case (mode)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, 14);
      default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: offers queued items at the falling edge, each after its gap
  // ---------------------------------------------------------------------------
  int         idle_left;
  bit         gap_armed;
  stim_item_t next_item;

  always @(negedge clk) begin
    if (rst_n) begin
      // the slot is free once the previous transaction went through
      if (!in_valid || in_taken) begin
        if (pending_items.size() != 0 && !gap_armed) begin
          idle_left = pending_items[0].gap;
          gap_armed = 1'b1;
        end
        if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_left > 0) begin
          idle_left = idle_left - 1;
          in_valid <= 1'b0;
        end else begin
          next_item = pending_items.pop_front();
          gap_armed = 1'b0;
          in_valid       <= 1'b1;
          in_opcode      <= next_item.op;
          in_packet_data <= next_item.data;
        end
      end
    end
  end

  // input monitor: every accepted transaction goes through the prediction
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(modulate_step(in_opcode, in_packet_data));
      items_taken = items_taken + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: stall pattern plus the occasional long hold
  // ---------------------------------------------------------------------------
  int stall_left;
  int hold_left;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) stall_left = draw_pause(stall_mode);
      // a long hold lets the block fill up and push back on its input
      if (holds_served != hold_requests) begin
        hold_left    = LONG_HOLD;
        holds_served = holds_served + 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result monitor: compare against the oldest prediction
  mod_result_t got, want;

  always @(posedge clk) begin
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_push_accepted, out_sample_valid, out_dac_sample, out_sending,
             out_packet_done, out_queue_level};
      if (expected_results.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result acc=%0b smp=%0b dac=%0d snd=%0b done=%0b lvl=%0d",
                   $realtime, got.push_ok, got.is_sample, got.dac, got.busy, got.last,
                   got.level);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected acc=%0b smp=%0b dac=%0d snd=%0b done=%0b lvl=%0d",
                     $realtime, want.push_ok, want.is_sample, want.dac, want.busy,
                     want.last, want.level);
            $display("%0t:          actual   acc=%0b smp=%0b dac=%0d snd=%0b done=%0b lvl=%0d",
                     $realtime, got.push_ok, got.is_sample, got.dac, got.busy,
                     got.last, got.level);
          end
        end
        if (want.is_sample) samples_checked = samples_checked + 1;
        else if (want.push_ok) pushes_stored = pushes_stored + 1;
        else pushes_refused = pushes_refused + 1;
        if (want.last) bursts_finished = bursts_finished + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic op, input logic [63:0] data);
    stim_item_t it;
    it.op   = op;
    it.data = data;
    it.gap  = draw_pause(gap_mode);
    pending_items.push_back(it);
  endtask

  // ticks with pushes mixed in, permille sets the push share
  task automatic tick_run(input int n, input int push_permille);
    logic [63:0] word;
    int          i;
    @(posedge clk);
    for (i = 0; i < n; i++) begin
      word = {$urandom, $urandom};
      if ($urandom_range(0, 999) < push_permille) begin
        case ($urandom_range(0, 5))
          0: word = 64'h0;
          1: word = '1;
          2: word = 64'hAAAA_AAAA_AAAA_AAAA;
          3: word = 64'h5555_5555_5555_5555;
          default: ;
        endcase
        queue_item(qam16_pkg::OP_PUSH, word);
      end else begin
        queue_item(qam16_pkg::OP_TICK, word);
      end
    end
  endtask

  // sender holds back until every predicted result has come out
  task automatic wait_idle();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_register(input logic [qam16_pkg::CFG_IDX_W-1:0] idx,
                              input logic [qam16_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      qam16_pkg::CFG_DC_OFFSET: dc_code  = int'(value[7:0]);
      qam16_pkg::CFG_GAIN:      gain_q16 = int'(value);
      qam16_pkg::CFG_REPEAT:    reps_cfg = int'(value[3:0]);
      default: ;
    endcase
    reg_writes = reg_writes + 1;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    int rounds;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = qam16_pkg::OP_TICK;
    in_packet_data = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = qam16_pkg::CFG_DC_OFFSET;
    cfg_wdata      = '0;
    store_wr  = '0;
    store_rd  = '0;
    pkt_count = 0;
    tx_word   = '0;
    sym_pos   = 0;
    rep_done  = 0;
    car_phase = 0;
    tx_active = 1'b0;
    dc_code   = 88;
    gain_q16  = 5800;
    reps_cfg  = 2;
    gap_mode   = PACE_BURSTY;
    stall_mode = PACE_BURSTY;
    for (p = 0; p < CAR_LEN; p++) begin
      sine_lut[p]   = trunc127_sine(64'(4 * p));
      cosine_lut[p] = trunc127_sine(64'(4 * p + CAR_LEN));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, idle carrier, queue filled to the brim
    queue_item(qam16_pkg::OP_TICK, 64'h0);
    queue_item(qam16_pkg::OP_TICK, '1);
    queue_item(qam16_pkg::OP_TICK, {$urandom, $urandom});
    queue_item(qam16_pkg::OP_PUSH, 64'h0);
    queue_item(qam16_pkg::OP_PUSH, '1);
    queue_item(qam16_pkg::OP_PUSH, 64'h0123_4567_89AB_CDEF);
    queue_item(qam16_pkg::OP_PUSH, 64'hFEDC_BA98_7654_3210);
    queue_item(qam16_pkg::OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_item(qam16_pkg::OP_PUSH, 64'h5555_5555_5555_5555);
    queue_item(qam16_pkg::OP_PUSH, {$urandom, $urandom});
    queue_item(qam16_pkg::OP_PUSH, {$urandom, $urandom});
    // queue full, both pushes must be refused
    queue_item(qam16_pkg::OP_PUSH, 64'hC3C3_3C3C_F00F_0FF0);
    queue_item(qam16_pkg::OP_TICK, 64'h0);
    queue_item(qam16_pkg::OP_TICK, 64'h0);
    queue_item(qam16_pkg::OP_PUSH, '1);
    queue_item(qam16_pkg::OP_TICK, {$urandom, $urandom});
    queue_item(qam16_pkg::OP_TICK, {$urandom, $urandom});

    // one period per symbol, first bursts go out while pushes keep the queue topped up
    wait_idle();
    set_register(qam16_pkg::CFG_REPEAT, 16'd1);
    tick_run(600, 20);

    // full-scale gain clips both rails; long output hold with a sender at full rate
    wait_idle();
    set_register(qam16_pkg::CFG_GAIN, 16'hFFFF);
    set_register(qam16_pkg::CFG_DC_OFFSET, 16'd128);
    gap_mode   = PACE_FULL;
    stall_mode = PACE_FULL;
    hold_requests = hold_requests + 1;
    tick_run(300, 0);

    // zero gain leaves the bare offset, at both ends of its range
    wait_idle();
    set_register(qam16_pkg::CFG_GAIN, 16'h0000);
    set_register(qam16_pkg::CFG_DC_OFFSET, 16'd0);
    gap_mode   = PACE_RANDOM;
    stall_mode = PACE_RANDOM;
    tick_run(100, 0);
    wait_idle();
    set_register(qam16_pkg::CFG_DC_OFFSET, 16'd255);
    tick_run(100, 0);

    // repeat count of zero behaves as one
    wait_idle();
    set_register(qam16_pkg::CFG_REPEAT, 16'd0);
    set_register(qam16_pkg::CFG_GAIN, 16'd30000);
    set_register(qam16_pkg::CFG_DC_OFFSET, 16'd200);
    gap_mode   = PACE_FULL;
    stall_mode = PACE_RANDOM;
    tick_run(300, 0);

    // longest symbols, cut short by a later change in the middle of a symbol
    wait_idle();
    set_register(qam16_pkg::CFG_REPEAT, 16'd15);
    set_register(qam16_pkg::CFG_GAIN, 16'd12000);
    set_register(qam16_pkg::CFG_DC_OFFSET, 16'd60);
    set_register(CFG_SPARE, 16'(($urandom)));
    gap_mode   = PACE_RANDOM;
    stall_mode = PACE_FULL;
    tick_run(150, 0);

    // keep the burst moving with fresh random settings on every round
    rounds = 0;
    while ((pkt_count != 0 || tx_active) && rounds < 2) begin
      wait_idle();
      set_register(qam16_pkg::CFG_DC_OFFSET, 16'($urandom_range(0, 255)));
      set_register(qam16_pkg::CFG_GAIN, 16'($urandom_range(0, 65535)));
      set_register(qam16_pkg::CFG_REPEAT, 16'($urandom_range(0, 1)));
      gap_mode   = $urandom_range(0, 2);
      stall_mode = $urandom_range(0, 2);
      tick_run(75, 0);
      rounds = rounds + 1;
    end

    // back at reset settings: idle carrier, then bursts starting from idle
    wait_idle();
    set_register(qam16_pkg::CFG_DC_OFFSET, 16'd88);
    set_register(qam16_pkg::CFG_GAIN, 16'd5800);
    set_register(qam16_pkg::CFG_REPEAT, 16'd2);
    gap_mode   = PACE_BURSTY;
    stall_mode = PACE_BURSTY;
    tick_run(150, 15);

    wait_idle();
    $display("run: %0d transactions in, %0d samples, %0d pushes stored, %0d refused",
             items_taken, samples_checked, pushes_stored, pushes_refused);
    $display("run: %0d bursts finished, %0d register writes incl. rail and repeat extremes",
             bursts_finished, reg_writes);
    if (fail_count == 0) begin
      $display("** qam16_burst_modulator_core: PASSED **");
    end else begin
      $display("** qam16_burst_modulator_core: FAILED **");
    end
    $finish;
  end

  // safety net against a hung handshake
  initial begin
    #80_000_000;
    $display("** qam16_burst_modulator_core: FAILED **");
    $finish;
  end

endmodule
